// ===== src/half_pixel_plane_interpolator_macros.svh =====
// Assertion macros for the half-pel plane interpolator.
`ifndef HALF_PIXEL_PLANE_INTERPOLATOR_MACROS_SVH
`define HALF_PIXEL_PLANE_INTERPOLATOR_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication on clk, idle during reset
`define HPI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication on clk, idle during reset
`define HPI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HPI_ASSERT_IMP(lbl, ante, cons)
`define HPI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/hpi_pkg.sv =====
// Shared constants and types of the half-pel plane interpolator.
package hpi_pkg;

	localparam int MAX_LINE_WIDTH = 2048;
	localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
	localparam int PIX_W          = 8;
	localparam int LINE_W         = 12;
	localparam int HEIGHT_W       = 16;
	localparam int CFG_W          = 16;
	// width that holds any configured width and the column count plus one
	localparam int CMP_W          = (LINE_W > COL_W + 1) ? LINE_W : COL_W + 1;

	localparam logic [LINE_W-1:0]   LINE_WIDTH_RST   = LINE_W'(2048);
	localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(1080);

	typedef enum logic [0:0] {
		CFG_LINE_WIDTH   = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_index_t;

	typedef logic [PIX_W-1:0] pix_t;

endpackage

// ===== src/half_pixel_plane_interpolator.sv =====
// Half-pel plane interpolator: line store, window registers and averaging.
// Usage:
//   Pixels arrive in raster order on the input channel (in_valid, in_stall,
//   pixel). Each accepted beat yields one result beat on the output channel
//   (out_valid, out_stall, up_avg, left_avg, diag_avg) carrying the vertical,
//   horizontal and 2x2 truncating averages around the pixel.
//   line_width and frame_height are set through the write port (cfg_we,
//   cfg_index, cfg_wdata) while the block is idle; 0 acts as 1 and a width
//   above the line store depth acts as the depth.
//   The pixel and its line store read are registered at the accepting
//   edge, and the result register loads from that read stage when the
//   output is ready. Throughput: one pixel per clock while the receiver
//   does not stall, set by the single-port line store that is read and
//   written once per accepted beat.
//   Reset clears counters, window registers and valids and restores the
//   register defaults (2048 x 1080); the line store is not cleared, so rows
//   below the top one see only pixels written since reset.
//   When the receiver stalls, the result register holds; an empty read
//   stage takes one more pixel, then in_stall is high until the output drains.
module half_pixel_plane_interpolator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  hpi_pkg::cfg_index_t    cfg_index,
	input  logic [hpi_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  hpi_pkg::pix_t          pixel,
	output logic                   out_valid,
	input  logic                   out_stall,
	output hpi_pkg::pix_t          up_avg,
	output hpi_pkg::pix_t          left_avg,
	output hpi_pkg::pix_t          diag_avg
);
	import hpi_pkg::*;

	`include "half_pixel_plane_interpolator_macros.svh"

	logic [LINE_W-1:0]   line_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;
	pix_t                left_q;
	pix_t                upleft_q;

	pix_t row_mem [MAX_LINE_WIDTH];

	logic s1_valid_s1;
	pix_t pixel_s1;
	pix_t left_s1;
	pix_t above_s1;
	logic top_s1;
	logic first_s1;

	logic out_ready;
	logic s1_adv;
	logic accept;

	logic [CMP_W-1:0]    eff_width;
	logic [CMP_W-1:0]    line_width_x;
	logic [HEIGHT_W-1:0] eff_height;
	logic                col_wrap;
	logic                row_wrap;

	logic [PIX_W:0]   up_sum;
	logic [PIX_W:0]   left_sum;
	logic [PIX_W+1:0] diag_sum;
	pix_t             up_c;
	pix_t             left_c;
	pix_t             diag_c;

	assign out_ready = !out_valid || !out_stall;
	assign s1_adv    = s1_valid_s1 && out_ready;
	assign in_stall  = s1_valid_s1 && !out_ready;
	assign accept    = in_valid && !in_stall;

	// clamp the configured width to 1..MAX_LINE_WIDTH
	assign line_width_x = CMP_W'(line_width_q);
	always_comb begin
		eff_width = line_width_x;
		if (line_width_q == '0) begin
			eff_width = CMP_W'(1);
		end else if (line_width_x > CMP_W'(MAX_LINE_WIDTH)) begin
			eff_width = CMP_W'(MAX_LINE_WIDTH);
		end
	end

	assign eff_height = (frame_height_q == '0) ? HEIGHT_W'(1) : frame_height_q;
	assign col_wrap   = (CMP_W'(col_q) + CMP_W'(1)) >= eff_width;
	assign row_wrap   = ({1'b0, row_q} + (HEIGHT_W+1)'(1)) >= {1'b0, eff_height};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_WIDTH:   line_width_q   <= cfg_wdata[LINE_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[HEIGHT_W-1:0];
				default:          ;
			endcase
		end
	end

	// position counters and left pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			left_q <= pixel;
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + HEIGHT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line store: read-first, so the read returns the previous row's pixel
	always_ff @(posedge clk) begin
		if (accept) begin
			above_s1       <= row_mem[col_q];
			row_mem[col_q] <= pixel;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			left_s1  <= left_q;
			top_s1   <= (row_q == '0);
			first_s1 <= (col_q == '0);
		end
	end

	// upper-left is the above pixel of the beat before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upleft_q <= '0;
		end else if (s1_adv) begin
			upleft_q <= above_s1;
		end
	end

	assign up_sum   = {1'b0, pixel_s1} + {1'b0, above_s1};
	assign left_sum = {1'b0, pixel_s1} + {1'b0, left_s1};
	assign diag_sum = {2'b00, pixel_s1} + {2'b00, left_s1}
		+ {2'b00, upleft_q} + {2'b00, above_s1};

	always_comb begin
		up_c   = top_s1   ? pixel_s1 : up_sum[PIX_W:1];
		left_c = first_s1 ? pixel_s1 : left_sum[PIX_W:1];
		if (top_s1) begin
			diag_c = left_c;
		end else if (first_s1) begin
			diag_c = up_c;
		end else begin
			diag_c = diag_sum[PIX_W+1:2];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			up_avg   <= up_c;
			left_avg <= left_c;
			diag_avg <= diag_c;
		end
	end

	`HPI_ASSERT_NXT(a_accept_fills_s1, accept, s1_valid_s1)
	`HPI_ASSERT_NXT(a_s1_holds, s1_valid_s1 && !out_ready,
		s1_valid_s1 && $stable(pixel_s1) && $stable(above_s1))
	`HPI_ASSERT_NXT(a_col_steps, accept && !col_wrap,
		col_q == $past(col_q) + COL_W'(1))
	`HPI_ASSERT_IMP(a_no_result_lost, s1_adv, !out_valid || !out_stall)

endmodule
